// ===== sv/assert_macros.svh =====
// Assertion macros shared by the classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Checks that a condition never occurs.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ===== sv/hlsc_pkg.sv =====
// Shared widths, register indexes and reset values of the HLS pixel classifier.
package hlsc_pkg;

  localparam int CHAN_W = 8;
  localparam int HUE_W = 8;
  localparam int FLOOR_W = 9;

  // Divider operands: rounded quotient is floor((2*n + d) / (2*d)), always below 256.
  localparam int NUM_W = 17;
  localparam int DEN_W = 9;
  localparam int QUO_W = 8;
  localparam int DIV_STAGES = 4;
  localparam int BITS_PER_STAGE = QUO_W / DIV_STAGES;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUE_LOW       = 3'd0,
    REG_HUE_HIGH      = 3'd1,
    REG_LUM_LOW       = 3'd2,
    REG_LUM_HIGH      = 3'd3,
    REG_LUM_SAT_FLOOR = 3'd4
  } cfg_index_t;

  localparam logic [HUE_W-1:0]   HUE_LOW_RST       = 8'd0;
  localparam logic [HUE_W-1:0]   HUE_HIGH_RST      = 8'd180;
  localparam logic [CHAN_W-1:0]  LUM_LOW_RST       = 8'd0;
  localparam logic [CHAN_W-1:0]  LUM_HIGH_RST      = 8'd255;
  localparam logic [FLOOR_W-1:0] LUM_SAT_FLOOR_RST = 9'd0;

endpackage

// ===== sv/hls_color_pixel_classifier_top.sv =====
// Throughput: one pixel per clock while in_stall is low; every stage is a register and
// each divider stage retires two quotient bits, so a new pixel may enter in such cycles.
// A skid register at the output keeps input stall a registered signal.
// Reset (synchronous, active high) clears all valid bits and loads the default thresholds.
module hls_color_pixel_classifier_top
  import hlsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAN_W-1:0]     blue,
  input  logic [CHAN_W-1:0]     green,
  input  logic [CHAN_W-1:0]     red,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  is_match,
  output logic [HUE_W-1:0]      hue_half,
  output logic [CHAN_W-1:0]     lightness,
  output logic [CHAN_W-1:0]     saturation
);

  // Which channel holds the maximum. Ties go to red, then green.
  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

  // One finished result as it leaves the pipeline.
  typedef struct packed {
    logic              is_match;
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] light;
    logic [CHAN_W-1:0] sat;
  } result_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the block is idle;
  // this is not enforced. The final compare stage uses the thresholds directly.
  // ---------------------------------------------------------------------------
  logic [HUE_W-1:0]   hue_low;
  logic [HUE_W-1:0]   hue_high;
  logic [CHAN_W-1:0]  lum_low;
  logic [CHAN_W-1:0]  lum_high;
  logic [FLOOR_W-1:0] lum_sat_floor;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_low       <= HUE_LOW_RST;
      hue_high      <= HUE_HIGH_RST;
      lum_low       <= LUM_LOW_RST;
      lum_high      <= LUM_HIGH_RST;
      lum_sat_floor <= LUM_SAT_FLOOR_RST;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        REG_HUE_LOW:       hue_low       <= cfg_data[HUE_W-1:0];
        REG_HUE_HIGH:      hue_high      <= cfg_data[HUE_W-1:0];
        REG_LUM_LOW:       lum_low       <= cfg_data[CHAN_W-1:0];
        REG_LUM_HIGH:      lum_high      <= cfg_data[CHAN_W-1:0];
        REG_LUM_SAT_FLOOR: lum_sat_floor <= cfg_data[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline enable. The whole pipeline moves together and freezes only while
  // the skid register holds a result, so nothing is dropped or repeated. Input
  // stall is the skid flag itself, which makes it a registered signal.
  // ---------------------------------------------------------------------------
  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // ---------------------------------------------------------------------------
  // Stage 1: maximum channel, spread, and the sum of maximum and minimum.
  // ---------------------------------------------------------------------------
  logic              s1_valid;
  max_sel_t          s1_sel;
  logic [CHAN_W-1:0] s1_d;
  logic [CHAN_W:0]   s1_sum;
  logic [CHAN_W-1:0] s1_blue;
  logic [CHAN_W-1:0] s1_green;
  logic [CHAN_W-1:0] s1_red;

  max_sel_t          sel_next;
  logic [CHAN_W-1:0] mx_next;
  logic [CHAN_W-1:0] mn_next;

  always_comb begin
    if (red >= green && red >= blue) begin
      sel_next = MAX_RED;
      mx_next  = red;
    end else if (green >= blue) begin
      sel_next = MAX_GREEN;
      mx_next  = green;
    end else begin
      sel_next = MAX_BLUE;
      mx_next  = blue;
    end
    mn_next = red;
    if (green < mn_next) begin
      mn_next = green;
    end
    if (blue < mn_next) begin
      mn_next = blue;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sel   <= sel_next;
      s1_d     <= mx_next - mn_next;
      s1_sum   <= {1'b0, mx_next} + {1'b0, mn_next};
      s1_blue  <= blue;
      s1_green <= green;
      s1_red   <= red;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: lightness, saturation denominator, and the signed channel
  // difference and sector offset that make up the hue numerator.
  // ---------------------------------------------------------------------------
  logic                     s2_valid;
  logic [CHAN_W-1:0]        s2_light;
  logic [CHAN_W-1:0]        s2_den;
  logic                     s2_grey;
  logic signed [CHAN_W:0]   s2_diff;
  logic [14:0]              s2_offs;
  logic [CHAN_W-1:0]        s2_d;

  logic [CHAN_W:0]        sum_inc;
  logic [CHAN_W:0]        den_wide;
  logic signed [CHAN_W:0] diff_next;
  logic [14:0]            offs_next;
  logic [14:0]            d15;

  always_comb begin
    sum_inc  = s1_sum + 9'd1;
    // Below the midpoint the denominator is the sum, above it the headroom.
    den_wide = (s1_sum < 9'd255) ? s1_sum : (9'd510 - s1_sum);
    d15      = 15'(s1_d);
    case (s1_sel)
      MAX_RED: begin
        diff_next = $signed({1'b0, s1_green}) - $signed({1'b0, s1_blue});
        offs_next = '0;
      end
      MAX_GREEN: begin
        diff_next = $signed({1'b0, s1_blue}) - $signed({1'b0, s1_red});
        offs_next = (d15 << 6) - (d15 << 2);
      end
      default: begin
        diff_next = $signed({1'b0, s1_red}) - $signed({1'b0, s1_green});
        offs_next = (d15 << 7) - (d15 << 3);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_light <= sum_inc[CHAN_W:1];
      s2_den   <= den_wide[CHAN_W-1:0];
      s2_grey  <= (s1_d == '0);
      s2_diff  <= diff_next;
      s2_offs  <= offs_next;
      s2_d     <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: raw hue numerator (30 times the difference plus the sector
  // offset) and the rounded saturation numerator 510*d + den.
  // ---------------------------------------------------------------------------
  logic                      s3_valid;
  logic signed [NUM_W-1:0]   s3_t;
  logic [NUM_W-1:0]          s3_sat_num;
  logic [CHAN_W-1:0]         s3_d;
  logic [CHAN_W-1:0]         s3_den;
  logic                      s3_grey;
  logic [CHAN_W-1:0]         s3_light;

  logic signed [NUM_W-1:0] diff17;
  logic [NUM_W-1:0]        d17_s2;

  always_comb begin
    diff17 = NUM_W'(s2_diff);
    d17_s2 = NUM_W'(s2_d);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_t       <= (diff17 <<< 5) - (diff17 <<< 1) + $signed(NUM_W'(s2_offs));
      s3_sat_num <= (d17_s2 << 9) - (d17_s2 << 1) + NUM_W'(s2_den);
      s3_d       <= s2_d;
      s3_den     <= s2_den;
      s3_grey    <= s2_grey;
      s3_light   <= s2_light;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: wrap a negative hue numerator by a full turn (180*d), form the
  // hue divider operands 2*t + d over 2*d, and pass 510*d + den over 2*den.
  // ---------------------------------------------------------------------------
  logic              s4_valid;
  logic [NUM_W-1:0]  s4_hue_num;
  logic [DEN_W-1:0]  s4_hue_den;
  logic [NUM_W-1:0]  s4_sat_num;
  logic [DEN_W-1:0]  s4_sat_den;
  logic              s4_grey;
  logic [CHAN_W-1:0] s4_light;

  logic [NUM_W-1:0] d17_s3;
  logic [NUM_W-1:0] turn;
  logic [NUM_W-1:0] t_wrap;

  always_comb begin
    d17_s3 = NUM_W'(s3_d);
    turn   = (d17_s3 << 7) + (d17_s3 << 5) + (d17_s3 << 4) + (d17_s3 << 2);
    t_wrap = s3_t[NUM_W-1] ? ($unsigned(s3_t) + turn) : $unsigned(s3_t);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_hue_num <= {t_wrap[NUM_W-2:0], 1'b0} + d17_s3;
      s4_hue_den <= {s3_d, 1'b0};
      s4_sat_num <= s3_sat_num;
      s4_sat_den <= {s3_den, 1'b0};
      s4_grey    <= s3_grey;
      s4_light   <= s3_light;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 5 to 8: two dividers in parallel. Grey flag and lightness ride
  // alongside in matching shift registers.
  // ---------------------------------------------------------------------------
  logic [QUO_W-1:0]  hue_quot;
  logic [QUO_W-1:0]  sat_quot;
  logic              dv_valid [DIV_STAGES];
  logic              dv_grey  [DIV_STAGES];
  logic [CHAN_W-1:0] dv_light [DIV_STAGES];

  hlsc_div u_hue_div (
    .clk  (clk),
    .en   (en),
    .num  (s4_hue_num),
    .den  (s4_hue_den),
    .quot (hue_quot)
  );

  hlsc_div u_sat_div (
    .clk  (clk),
    .en   (en),
    .num  (s4_sat_num),
    .den  (s4_sat_den),
    .quot (sat_quot)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dv_grey[0]  <= s4_grey;
      dv_light[0] <= s4_light;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dv_grey[i]  <= dv_grey[i-1];
        dv_light[i] <= dv_light[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 9: grey pixels force hue and saturation to zero; then the window
  // compares and the lightness plus saturation floor.
  // ---------------------------------------------------------------------------
  logic    p_valid;
  result_t p_res;
  result_t p_res_next;

  logic [HUE_W-1:0]   hue_fin;
  logic [CHAN_W-1:0]  sat_fin;
  logic [CHAN_W-1:0]  light_fin;
  logic [FLOOR_W-1:0] lum_sat;

  always_comb begin
    hue_fin   = dv_grey[DIV_STAGES-1] ? '0 : hue_quot;
    sat_fin   = dv_grey[DIV_STAGES-1] ? '0 : sat_quot;
    light_fin = dv_light[DIV_STAGES-1];
    lum_sat   = {1'b0, light_fin} + {1'b0, sat_fin};
    p_res_next.is_match = (hue_fin >= hue_low) && (hue_fin <= hue_high) &&
                          (light_fin >= lum_low) && (light_fin <= lum_high) &&
                          (lum_sat >= lum_sat_floor);
    p_res_next.hue   = hue_fin;
    p_res_next.light = light_fin;
    p_res_next.sat   = sat_fin;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_res <= p_res_next;
    end
  end

  // Valid bits travel with the data and are the only pipeline state that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) begin
        dv_valid[i] <= 1'b0;
      end
      p_valid <= 1'b0;
    end else if (en) begin
      s1_valid    <= in_valid;
      s2_valid    <= s1_valid;
      s3_valid    <= s2_valid;
      s4_valid    <= s3_valid;
      dv_valid[0] <= s4_valid;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dv_valid[i] <= dv_valid[i-1];
      end
      p_valid <= dv_valid[DIV_STAGES-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid register. A result that reaches the end while the
  // output holds a stalled transaction parks in the skid register, which then
  // freezes the pipeline until the output drains.
  // ---------------------------------------------------------------------------
  result_t out_res;
  result_t skid_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (p_valid) begin
      if (!out_valid || !out_stall) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_stall) begin
        out_res <= skid_res;
      end
    end else if (p_valid) begin
      if (!out_valid || !out_stall) begin
        out_res <= p_res;
      end else begin
        skid_res <= p_res;
      end
    end
  end

  assign is_match   = out_res.is_match;
  assign hue_half   = out_res.hue;
  assign lightness  = out_res.light;
  assign saturation = out_res.sat;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_skid_has_out, clk, rst, skid_valid, out_valid, "skid full while output empty")
  `ASSERT_IMPLIES(a_skid_fill, clk, rst, $rose(skid_valid), $past(out_valid && out_stall), "skid filled without a stalled output")
  `ASSERT_NEXT(a_frozen_pipe, clk, rst, skid_valid && !$past(rst), $stable(p_valid), "pipeline moved while skid full")
  `ASSERT_NEVER(a_hue_range, clk, rst, out_valid && (hue_half > 8'd180), "hue above 180")

endmodule

// ===== sv/hlsc_div.sv =====
// Pipelined restoring divider that yields an 8-bit quotient over four stages.
module hlsc_div
  import hlsc_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quot
);

  logic [NUM_W-1:0] rem_q [DIV_STAGES];
  logic [DEN_W-1:0] den_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [NUM_W-1:0] rem_n;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [QUO_W-1:0] quo_n;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    // Each stage retires the next quotient bits, most significant first.
    always_comb begin
      logic [NUM_W-1:0] trial;
      rem_n = rem_in;
      quo_n = quo_in;
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        trial = NUM_W'(den_in) << (QUO_W - 1 - s * BITS_PER_STAGE - j);
        if (rem_n >= trial) begin
          rem_n = rem_n - trial;
          quo_n = {quo_n[QUO_W-2:0], 1'b1};
        end else begin
          quo_n = {quo_n[QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= rem_n;
        den_q[s] <= den_in;
        quo_q[s] <= quo_n;
      end
    end
  end

  assign quot = quo_q[DIV_STAGES-1];

endmodule
